@@ rtl/core/bch_pkg.sv @@
// package for brightness/contrast histogram block
// shared types and constants; no dependencies
package bch_pkg;
    localparam int NUM_BINS = 256;
    localparam int BIN_BITS = 8;
    localparam int BAR_BITS = 9;
    localparam logic [BAR_BITS-1:0] BAR_MAX = 9'd511;

    typedef enum logic [0:0] { FUNC_PIXEL = 1'b0, FUNC_READ = 1'b1 } func_t;
    typedef enum logic [0:0] { REG_BRIGHTNESS = 1'b0, REG_CONTRAST = 1'b1 } reg_idx_t;

    // request passed from front to back
    typedef struct packed {
        logic       is_read;
        logic [7:0] value;     // adjusted pixel or bin index
        logic       frame_end;
    } bch_req_t;
endpackage

@@ rtl/core/bch_stream_if.sv @@
// valid/ready stream interface with a generic payload
// depends on nothing
interface bch_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bch_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle, round half to even
// depends on nothing
module bch_div #(
    parameter int NB = 40,
    parameter int DB = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NB-1:0]        num,
    input  logic [DB-1:0]        den,
    output logic                 busy,
    output logic                 done,
    output logic [NB-1:0]        quo
);
    localparam int CB = $clog2(NB + 1);
    logic [NB-1:0] q_reg, q_next;
    logic [DB:0]   r_reg, r_next;
    logic [DB-1:0] d_reg;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          busy_reg, done_reg;
    logic [DB:0]   trial;
    logic [DB+1:0] twice;

    always_comb
    begin
        trial  = {r_reg[DB-1:0], q_reg[NB-1]};
        q_next = {q_reg[NB-2:0], 1'b0};
        r_next = trial;
        if (trial >= {1'b0, d_reg})
        begin
            r_next    = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
        cnt_next = cnt_reg - CB'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_next == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    // rounding at the end
    always_comb
    begin
        twice = {r_reg, 1'b0};
        quo   = q_reg;
        if (twice > {2'b00, d_reg} || (twice == {2'b00, d_reg} && q_reg[0]))
            quo = q_reg + NB'(1);
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule

@@ rtl/core/bch_front.sv @@
// front end: computes the adjusted pixel, classifies items, fills the queue
// depends on bch_pkg, bch_div
module bch_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [7:0]          gray_in,
    input  logic                frame_end,
    input  logic [7:0]          bin_index,
    input  logic [7:0]          brightness_reg,
    input  logic [7:0]          contrast_reg,
    output logic                q_valid,
    input  logic                q_ready,
    output bch_pkg::bch_req_t   q_req
);
    import bch_pkg::*;

    // numerator below 2^24 in magnitude, denominator below 2^15
    localparam int NB = 28;
    localparam int DB = 17;

    logic signed [9:0]  br, c;
    logic signed [9:0]  xb;
    logic signed [31:0] num_s, den_s;
    logic               neg;
    logic [NB-1:0]      num_a, quo;
    logic [DB-1:0]      den_a;
    logic               busy, done, start;
    logic               hold_reg;
    bch_req_t           req_reg;
    logic               fe_reg;
    logic               neg_reg;
    logic [7:0]         pix;
    logic signed [NB:0] v;

    assign br = $signed({2'b00, brightness_reg}) - 10'sd100;
    assign c  = $signed({2'b00, contrast_reg})   - 10'sd100;
    assign xb = $signed({2'b00, gray_in}) + br;

    // rational of the transfer curve
    always_comb
    begin
        if (c > 10'sd0)
        begin
            num_s = 32'sd255 * (32'sd100 * 32'(xb) - 32'sd127 * 32'(c));
            den_s = 32'sd25500 - 32'sd254 * 32'(c);
        end
        else
        begin
            num_s = (32'sd25600 + 32'sd256 * 32'(c)) * 32'(xb) - 32'sd32640 * 32'(c);
            den_s = 32'sd25500;
        end
        neg   = num_s[31] ^ den_s[31];
        num_a = NB'(num_s[31] ? -num_s : num_s);
        den_a = DB'(den_s[31] ? -den_s : den_s);
    end

    // a pixel goes to the divider; a read goes straight to the queue
    assign in_ready = !busy && !done && !hold_reg;
    assign start    = in_valid && in_ready && (func == FUNC_PIXEL);

    bch_div #(.NB(NB), .DB(DB)) u_div (
        .clk(clk), .rst_n(rst_n), .start(start), .num(num_a), .den(den_a),
        .busy(busy), .done(done), .quo(quo)
    );

    // signed rounded value, then clamp
    always_comb
    begin
        v = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        if (v < 0)
            pix = 8'd0;
        else if (v > 255)
            pix = 8'd255;
        else
            pix = v[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (in_valid && in_ready && func == FUNC_READ)
            hold_reg <= 1'b1;
        else if (done)
            hold_reg <= 1'b1;
        else if (q_valid && q_ready)
            hold_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fe_reg  <= frame_end;
            neg_reg <= neg;
            if (func == FUNC_READ)
                req_reg <= '{is_read: 1'b1, value: bin_index, frame_end: 1'b0};
        end
        if (done)
            req_reg <= '{is_read: 1'b0, value: pix, frame_end: fe_reg};
    end

    assign q_valid = hold_reg;
    assign q_req   = req_reg;
endmodule

@@ rtl/core/bch_back.sv @@
// back end: histogram memory update, clear sweep, bar scaling
// depends on bch_pkg, bch_div
module bch_back #(
    parameter int COUNT_BITS = 22,
    parameter int BAR_SCALE  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  bch_pkg::bch_req_t q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        adjusted_pixel,
    output logic [8:0]        bar_height
);
    import bch_pkg::*;

    localparam int SB = $clog2(BAR_SCALE + 1);
    localparam int NB = COUNT_BITS + SB;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_RD    = 6'b000100,
        S_UPD   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rd_reg, max_reg, cnt_inc;
    logic [BIN_BITS:0]     clr_reg;
    logic                  done_frame_reg;
    bch_req_t              cur_reg;
    logic [7:0]            px_reg;
    logic [8:0]            bar_reg;
    logic                  dstart, dbusy, ddone;
    logic [NB-1:0]         dquo;
    logic                  mem_we;
    logic [BIN_BITS-1:0]   mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;

    assign q_ready = (state_reg == S_IDLE);
    assign cnt_inc = (&rd_reg) ? rd_reg : rd_reg + COUNT_BITS'(1);
    // the bin count is registered by the end of the read state, so the divider starts in the divide state that follows
    assign dstart  = (state_reg == S_DIV) && !dbusy && !ddone;

    bch_div #(.NB(NB), .DB(COUNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num(NB'(rd_reg) * NB'(BAR_SCALE)), .den(max_reg),
        .busy(dbusy), .done(ddone), .quo(dquo)
    );

    always_comb
    begin
        state_next = state_reg;
        mem_we = 1'b0;
        mem_wa = clr_reg[BIN_BITS-1:0];
        mem_wd = '0;
        unique case (state_reg)
            S_IDLE:
                if (q_valid)
                    state_next = (!q_req.is_read && done_frame_reg) ? S_CLEAR : S_RD;
            S_CLEAR:
            begin
                mem_we = 1'b1;
                // a frame restart goes on with its pixel, the pass after reset goes idle
                if (clr_reg[BIN_BITS])
                    state_next = done_frame_reg ? S_RD : S_IDLE;
            end
            S_RD:
                if (cur_reg.is_read)
                    state_next = (max_reg != '0) ? S_DIV : S_OUT;
                else
                    state_next = S_UPD;
            S_UPD:
            begin
                mem_we = 1'b1;
                mem_wa = cur_reg.value;
                mem_wd = cnt_inc;
                state_next = S_OUT;
            end
            S_DIV:
                if (ddone)
                    state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // histogram memory; clear sweep writes zero
    always_ff @(posedge clk)
    begin
        if (mem_we && !(state_reg == S_CLEAR && clr_reg[BIN_BITS]))
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[cur_reg.value];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            max_reg        <= '0;
            done_frame_reg <= 1'b0;
            cur_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && q_valid)
            begin
                cur_reg <= q_req;
                clr_reg <= '0;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
                max_reg <= '0;
                if (clr_reg[BIN_BITS])
                    done_frame_reg <= 1'b0;
            end
            if (state_reg == S_UPD)
            begin
                if (cnt_inc > max_reg)
                    max_reg <= cnt_inc;
                if (cur_reg.frame_end)
                    done_frame_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            px_reg  <= cur_reg.is_read ? 8'd0 : cur_reg.value;
            bar_reg <= 9'd0;
        end
        if (ddone)
            bar_reg <= (dquo > NB'(BAR_MAX)) ? BAR_MAX : dquo[8:0];
    end

    assign out_valid      = (state_reg == S_OUT);
    assign adjusted_pixel = px_reg;
    assign bar_height     = bar_reg;
endmodule

@@ rtl/core/brightness_contrast_histogram.sv @@
// a pixel passes the front's bit-serial divider, a bar read the back's unless the peak count is zero
// a pixel that opens a new frame also waits for the clearing pass
// throughput: one item at a time through each side; the front divides the next pixel
// while the back updates the histogram memory
// reset: settings go to 100, then a clearing pass over every bin; the back takes no request meanwhile
// depends on bch_pkg, bch_stream_if, bch_front, bch_back
module brightness_contrast_histogram #(
    parameter int COUNT_BITS = 22,
    parameter int BAR_SCALE  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    bch_stream_if.sink   in_req,
    bch_stream_if.source out_res
);
    import bch_pkg::*;

    logic [7:0] brightness_reg, contrast_reg;
    logic       q_valid, q_ready;
    bch_req_t   q_req;
    logic [7:0] adjusted_pixel;
    logic [8:0] bar_height;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 8'd100;
            contrast_reg   <= 8'd100;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BRIGHTNESS)
                brightness_reg <= cfg_data;
            else
                contrast_reg <= cfg_data;
        end
    end

    bch_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_req.valid), .in_ready(in_req.ready),
        .func(in_req.data[0]), .gray_in(in_req.data[8:1]),
        .frame_end(in_req.data[9]), .bin_index(in_req.data[17:10]),
        .brightness_reg(brightness_reg), .contrast_reg(contrast_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    bch_back #(.COUNT_BITS(COUNT_BITS), .BAR_SCALE(BAR_SCALE)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(out_res.valid), .out_ready(out_res.ready),
        .adjusted_pixel(adjusted_pixel), .bar_height(bar_height)
    );

    assign out_res.data = {bar_height, adjusted_pixel};
endmodule

@@ rtl/core/bch_checker.sv @@
// port-level checks for the histogram block, bound to the top level
// depends on nothing
module bch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] out_data
);
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    // a result is either a pixel or a bar, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data[7:0] == 8'd0 || out_data[16:8] == 9'd0)
        else $error("mixed result");
    // no request is taken in the cycle after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("double accept");
endmodule

bind brightness_contrast_histogram bch_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_req.valid), .in_ready(in_req.ready),
    .out_valid(out_res.valid), .out_ready(out_res.ready),
    .out_data(out_res.data)
);

@@ tb/brightness_contrast_histogram_tb.sv @@
// testbench for brightness_contrast_histogram: directed and random pixel/read traffic
// checked against an internal histogram predictor; depends on bch_pkg, bch_stream_if and brightness_contrast_histogram
module brightness_contrast_histogram_tb;
    import bch_pkg::*;

    localparam int  COUNT_BITS = 22;
    localparam int  BAR_SCALE  = 256;
    localparam int  REQ_W      = 18;   // {bin_index, frame_end, gray_in, func}
    localparam int  RES_W      = 17;   // {bar_height, adjusted_pixel}
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [8:0] bar;
        logic [7:0] pixel;
    } bch_result_t;

    logic clk;
    logic rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    bch_stream_if #(.W(REQ_W)) req_ch ();
    bch_stream_if #(.W(RES_W)) res_ch ();

    brightness_contrast_histogram #(
        .COUNT_BITS(COUNT_BITS),
        .BAR_SCALE (BAR_SCALE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_req   (req_ch.sink),
        .out_res  (res_ch.source)
    );

    // predictor state
    longint      bin_count [NUM_BINS];
    longint      peak_count;
    bit          frame_closed;
    logic [7:0]  bright_set;
    logic [7:0]  contrast_set;
    bch_result_t pending_results [$];

    int     fail_count;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // round to nearest, ties to even
    function automatic longint div_round_even(longint num, longint den);
        longint q;
        longint r;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        q = num / den;
        r = num - q * den;
        if (r < 0)
        begin
            q = q - 1;
            r = r + den;
        end
        if (2 * r > den || (2 * r == den && q[0]))
            q = q + 1;
        return q;
    endfunction

    // brightness/contrast curve
    function automatic logic [7:0] tone_map(logic [7:0] gray);
        longint br;
        longint c;
        longint xb;
        longint v;
        br = longint'(bright_set) - 100;
        c  = longint'(contrast_set) - 100;
        xb = longint'(gray) + br;
        if (c > 0)
            v = div_round_even(255 * (100 * xb - 127 * c), 25500 - 254 * c);
        else
            v = div_round_even((25600 + 256 * c) * xb - 32640 * c, 25500);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // scaled bar height of one bin
    function automatic logic [8:0] bar_height_of(logic [7:0] idx);
        longint num;
        longint q;
        longint r;
        if (peak_count == 0)
            return 9'd0;
        num = bin_count[idx] * BAR_SCALE;
        q = num / peak_count;
        r = num - q * peak_count;
        if (2 * r > peak_count || (2 * r == peak_count && q[0]))
            q = q + 1;
        if (q > 511)
            q = 511;
        return q[8:0];
    endfunction

    // prediction for one accepted request: histogram update for a pixel, bar height for a read
    function automatic void predict_request(logic func, logic [7:0] gray, logic fend,
                                            logic [7:0] idx);
        bch_result_t res;
        logic [7:0]  px;
        if (func == FUNC_PIXEL)
        begin
            if (frame_closed)
            begin
                foreach (bin_count[i])
                    bin_count[i] = 0;
                peak_count = 0;
                frame_closed = 1'b0;
            end
            px = tone_map(gray);
            if (bin_count[px] < (longint'(1) << COUNT_BITS) - 1)
                bin_count[px] = bin_count[px] + 1;
            if (bin_count[px] > peak_count)
                peak_count = bin_count[px];
            if (fend)
                frame_closed = 1'b1;
            res.pixel = px;
            res.bar   = 9'd0;
        end
        else
        begin
            res.pixel = 8'd0;
            res.bar   = bar_height_of(idx);
        end
        pending_results.push_back(res);
    endfunction

    // send one request; caller is at a falling edge
    task automatic send_request(logic func, logic [7:0] gray, logic fend, logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= REQ_W'($urandom);
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= {idx, fend, gray, func};
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(func, gray, fend, idx);
        @(negedge clk);
    endtask

    task automatic send_pixel(logic [7:0] gray, logic fend);
        send_request(FUNC_PIXEL, gray, fend, 8'($urandom));
    endtask

    task automatic send_read(logic [7:0] idx);
        send_request(FUNC_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // register write while idle
    task automatic write_setting(reg_idx_t idx, logic [7:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BRIGHTNESS)
            bright_set = value;
        else
            contrast_set = value;
    endtask

    task automatic set_tone(logic [7:0] b, logic [7:0] c);
        write_setting(REG_BRIGHTNESS, b);
        write_setting(REG_CONTRAST, c);
    endtask

    // receiver backpressure
    always @(negedge clk)
    begin
        if (rst_n)
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        bch_result_t got;
        bch_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual pixel %0d bar %0d",
                         $time, got.pixel, got.bar);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.pixel !== want.pixel)
                begin
                    $display("%0t: adjusted_pixel mismatch: expected %0d, actual %0d",
                             $time, want.pixel, got.pixel);
                    fail_count = fail_count + 1;
                end
                if (got.bar !== want.bar)
                begin
                    $display("%0t: bar_height mismatch: expected %0d, actual %0d",
                             $time, want.bar, got.bar);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // extremes of fields and settings, reads on an empty store, frame restart
    task automatic test_directed();
        send_read(8'd0);                 // max count still zero
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_read(8'd255);
        send_read(8'd0);
        send_pixel(8'd128, 1'b1);        // frame end
        send_read(8'd128);               // store still shows the closed frame
        send_request(FUNC_READ, 8'd0, 1'b1, 8'd255);  // frame end ignored on reads
        send_pixel(8'd7, 1'b0);          // frame restart clears the store
        send_read(8'd255);
        set_tone(8'd0, 8'd0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        set_tone(8'd200, 8'd200);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd128, 1'b0);
        set_tone(8'd255, 8'd255);        // above range, negative divisor
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        set_tone(8'd255, 8'd201);
        send_pixel(8'd100, 1'b0);
        send_read(8'd255);
        send_read(8'd0);
        set_tone(8'd100, 8'd100);
    endtask

    // frames of random pixels with interleaved reads and some noise
    task automatic test_random_frames(int n_items);
        int sent;
        int frame_len;
        sent = 0;
        while (sent < n_items)
        begin
            frame_len = $urandom_range(60, 1);
            for (int k = 0; k < frame_len && sent < n_items; k++)
            begin
                if ($urandom_range(99) < 20)
                    send_read(8'($urandom));
                else if ($urandom_range(99) < 5)
                    send_pixel(8'($urandom), 1'b1);  // stray frame end
                else if ($urandom_range(99) < 30)
                    send_pixel(8'($urandom_range(140, 110)), 1'b0);  // tall peaks
                else
                    send_pixel(8'($urandom), k == frame_len - 1);
                sent++;
            end
        end
    endtask

    // one idling phase across several tone settings
    task automatic test_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_tone(8'($urandom_range(200)), 8'($urandom_range(200)));
        test_random_frames(130);
        set_tone(8'($urandom_range(255)), 8'($urandom_range(255)));
        test_random_frames(130);
        set_tone(8'd100, 8'($urandom_range(100)));
        test_random_frames(130);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_BRIGHTNESS;
        cfg_data       = 8'd0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        res_ch.ready   = 1'b0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bright_set     = 8'd100;
        contrast_set   = 8'd100;
        peak_count     = 0;
        frame_closed   = 1'b0;
        foreach (bin_count[i])
            bin_count[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_phase(0, 0);
        test_phase(63, 0);
        test_phase(0, 63);
        test_phase(26, 26);

        drain_results();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
